FILE: src/optimization_benchmark_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Optimization benchmark evaluator - assertion macros
// Clocked assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef OPTIMIZATION_BENCHMARK_EVALUATOR_MACROS_SVH
`define OPTIMIZATION_BENCHMARK_EVALUATOR_MACROS_SVH

// Checked only while out of reset
`define OBE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define OBE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/obe_pkg.sv
// ----------------------------------------------------------------------------
// obe_pkg
// Types, fixed-point constants and the CORDIC arctangent table shared by the
// benchmark evaluator modules.
// ----------------------------------------------------------------------------
package obe_pkg;

    localparam int COORD_W = 31;
    localparam int SCORE_W = 35;
    localparam int IDX_W   = 10;  // coordinate index in a queued item
    localparam int SUM_W   = 48;
    localparam int TERM_W  = 42;
    localparam int SCR_W   = 49;  // score before saturation
    localparam int DIV_W   = 61;  // dividend / quotient width
    localparam int DEN_W   = 44;  // divisor width
    localparam int SQ_W    = 62;  // square root radicand width
    localparam int ROOT_W  = SQ_W / 2;

    // divide by 125 as a multiply by ceil(2^46/125), exact below 2^39
    localparam int          CD_N_W = 39;
    localparam int          CD_K   = 46;
    localparam logic [39:0] CD_M   = 40'd562949953422;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_RAST  = 2'd0;
    localparam t_mode MODE_GRIEW = 2'd1;
    localparam t_mode MODE_SCHAF = 2'd2;
    localparam t_mode MODE_NONE  = 2'd3;

    // register byte addresses
    localparam logic [2:0] ADDR_MODE = 3'd0;

    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam logic [31:0]        ONE_Q20     = 32'd1048576;
    localparam logic signed [31:0] CORDIC_K    = 32'sd652032874;
    localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
    localparam logic [31:0]        TURNS_RAD   = 32'd683565276;
    localparam logic [SUM_W-1:0]   SUM_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [SCR_W-1:0]   SCORE_TOP   = 49'd31457280000;
    localparam logic [SUM_W-1:0]   R2_CAP      = 48'h0200_0000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_value;
        logic                      last_coord;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] score_value;
        logic               dim_overflow;
    } t_out_item;

    // item as queued between front and back
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic [IDX_W-1:0]          k;
        logic                      term_en;
        t_mode                     mode;
        logic                      last;
        logic                      ovf;
    } t_cmd;

    // atan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd31:   v = 30'd0;
            default: v = 30'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

FILE: src/obe_cordic.sv
// ----------------------------------------------------------------------------
// obe_cordic
// Iterative rotation-mode CORDIC: cosine and sine in Q30 of a 32-bit turn
// phase, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module obe_cordic
    import obe_pkg::*;
#(
    parameter int ITERS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_phase,
    output logic               o_busy,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    typedef enum logic [1:0] {ST_IDLE, ST_ANGLE, ST_ROT, ST_FIX} t_state;

    t_state              r_state;
    logic [1:0]          r_quad;
    logic signed [31:0]  r_red;
    logic signed [33:0]  r_x, r_y, r_z;
    logic [4:0]          r_it;

    logic [31:0]         w_ph;
    logic signed [63:0]  w_zp;
    logic signed [33:0]  w_dx, w_dy, w_at;
    logic signed [31:0]  w_cx, w_cy;

    // quadrant fold
    assign w_ph = i_phase + 32'h2000_0000;
    assign w_zp = r_red * HALF_PI_Q30;

    // shift-add step
    assign w_dx = r_y >>> r_it;
    assign w_dy = r_x >>> r_it;
    assign w_at = $signed({4'b0000, atan_q30(r_it)});

    // clamp to +-1.0
    always_comb begin
        if (r_x > 34'sd1073741824) begin
            w_cx = ONE_Q30;
        end else if (r_x < -34'sd1073741824) begin
            w_cx = -ONE_Q30;
        end else begin
            w_cx = r_x[31:0];
        end
        if (r_y > 34'sd1073741824) begin
            w_cy = ONE_Q30;
        end else if (r_y < -34'sd1073741824) begin
            w_cy = -ONE_Q30;
        end else begin
            w_cy = r_y[31:0];
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_quad  <= w_ph[31:30];
                        r_red   <= $signed(i_phase - {w_ph[31:30], 30'd0});
                        r_state <= ST_ANGLE;
                    end
                end
                ST_ANGLE: begin
                    r_z     <= w_zp[63:30];
                    r_x     <= 34'(CORDIC_K);
                    r_y     <= '0;
                    r_it    <= '0;
                    r_state <= ST_ROT;
                end
                ST_ROT: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_at;
                    end
                    if (r_it == 5'(ITERS - 1)) begin
                        r_state <= ST_FIX;
                    end else begin
                        r_it <= r_it + 5'd1;
                    end
                end
                ST_FIX: begin
                    unique case (r_quad)
                        2'd0: begin o_cos <= w_cx;  o_sin <= w_cy;  end
                        2'd1: begin o_cos <= -w_cy; o_sin <= w_cx;  end
                        2'd2: begin o_cos <= -w_cx; o_sin <= -w_cy; end
                        2'd3: begin o_cos <= w_cy;  o_sin <= -w_cx; end
                    endcase
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: src/obe_div.sv
// ----------------------------------------------------------------------------
// obe_div
// Restoring unsigned divider, one quotient bit per cycle, and a reciprocal
// divider by the constant 125 that sums four partial products.
// ----------------------------------------------------------------------------
module obe_div
    import obe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   w_sh;
    logic             w_ge;

    // trial subtract
    assign w_sh = {r_rem, r_num[DIV_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    assign o_busy = r_busy;
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end
        end else begin
            r_rem <= w_ge ? DEN_W'(w_sh - {1'b0, r_den}) : w_sh[DEN_W-1:0];
            r_num <= {r_num[DIV_W-2:0], w_ge};
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

// Divide by 125: num * ceil(2^46/125) >> 46, built from four 20x20 partial
// products accumulated one per cycle.
module obe_cdiv
    import obe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CD_N_W-1:0] i_num,
    output logic              o_busy,
    output logic [31:0]       o_quot
);

    logic              r_busy;
    logic [1:0]        r_step;
    logic [CD_N_W-1:0] r_num;
    logic [79:0]       r_acc;
    logic [19:0]       w_a, w_b;
    logic [39:0]       w_pp;
    logic [79:0]       w_pp_sh;

    // halves of operand and constant for this step
    assign w_a  = r_step[1] ? 20'(r_num[CD_N_W-1:20]) : r_num[19:0];
    assign w_b  = r_step[0] ? CD_M[39:20] : CD_M[19:0];
    assign w_pp = w_a * w_b;

    // align the partial product
    always_comb begin
        unique case (r_step)
            2'd0:    w_pp_sh = {40'd0, w_pp};
            2'd3:    w_pp_sh = {w_pp, 40'd0};
            default: w_pp_sh = {20'd0, w_pp, 20'd0};
        endcase
    end

    assign o_busy = r_busy;
    assign o_quot = r_acc[CD_K+31:CD_K];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_num;
                r_acc  <= '0;
            end
        end else begin
            r_acc <= r_acc + w_pp_sh;
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

endmodule

FILE: src/obe_sqrt.sv
// ----------------------------------------------------------------------------
// obe_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module obe_sqrt
    import obe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_val,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 3;

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQ_W-1:0]   r_val;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  w_sh, w_trial;
    logic              w_ge;

    // bring down two bits, try root*4+1
    assign w_sh    = {r_rem[REM_W-3:0], r_val[SQ_W-1:SQ_W-2]};
    assign w_trial = REM_W'({r_root, 2'b01});
    assign w_ge    = (w_sh >= w_trial);

    assign o_busy = r_busy;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_val;
                r_root <= '0;
                r_rem  <= '0;
            end
        end else begin
            r_val  <= {r_val[SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_sh - w_trial) : w_sh;
            r_root <= {r_root[ROOT_W-2:0], w_ge};
            if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

FILE: src/obe_front.sv
// ----------------------------------------------------------------------------
// obe_front
// Takes coordinates, tracks the vector index and overflow, and queues tagged
// items for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module obe_front
    import obe_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  t_mode    i_mode,
    output logic     o_busy,
    input  logic     i_pop,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic [CNT_W-1:0] r_idx;
    logic             r_ovf;
    t_cmd             r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    logic             w_push, w_skip;
    t_cmd             w_cmd;

    assign o_busy      = (r_cnt == 2'd2);
    assign w_push      = i_start && !o_busy;
    assign w_skip      = (r_idx >= CNT_W'(MAX_DIM));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // classify the item
    always_comb begin
        w_cmd.x       = i_item.coord_value;
        w_cmd.k       = IDX_W'(r_idx);
        w_cmd.term_en = !w_skip;
        w_cmd.mode    = i_mode;
        w_cmd.last    = i_item.last_coord;
        w_cmd.ovf     = r_ovf || w_skip;
    end

    // vector position and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ovf <= 1'b0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
                if (i_item.last_coord) begin
                    r_idx <= '0;
                    r_ovf <= 1'b0;
                end else if (w_skip) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

FILE: src/obe_back.sv
// ----------------------------------------------------------------------------
// obe_back
// Sequencer that applies each queued item to the accumulators and computes
// the score, sharing one CORDIC, one divider, one square root unit and one
// divide-by-125 unit.
// ----------------------------------------------------------------------------
module obe_back
    import obe_pkg::*;
#(
    parameter int CORDIC_ITERS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_result_valid,
    output t_out_item o_result
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_R_WCOS,
        ST_G_DIV, ST_G_SQRT, ST_G_MUL1, ST_G_MUL2, ST_G_COS, ST_G_WCOS, ST_G_CP,
        ST_G_WDIV, ST_ADD, ST_FIN,
        ST_S_START, ST_S_WSQRT, ST_S_PHASE, ST_S_WCOS, ST_S_SIN2, ST_S_DSQ,
        ST_S_DIV, ST_S_WDIV, ST_OUT
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [SUM_W-1:0]    r_sum;
    logic signed [31:0]  r_cp;
    logic [60:0]         r_xx;
    logic [ROOT_W-1:0]   r_rsq;
    logic signed [63:0]  r_prod;
    logic [TERM_W-1:0]   r_term;
    logic [SCR_W-1:0]    r_score;
    logic [SUM_W-1:0]    r_r2;
    logic [31:0]         r_sin2;
    logic [31:0]         r_d;
    logic                r_neg;

    // shared units
    logic                cor_start, cor_busy;
    logic [31:0]         cor_phase;
    logic signed [31:0]  cor_cos, cor_sin;
    logic                div_start, div_busy;
    logic [DIV_W-1:0]    div_num, div_quot;
    logic [DEN_W-1:0]    div_den;
    logic                sq_start, sq_busy;
    logic [SQ_W-1:0]     sq_val;
    logic [ROOT_W-1:0]   sq_root;
    logic                cd_start, cd_busy;
    logic [CD_N_W-1:0]   cd_num;
    logic [31:0]         cd_quot;

    logic signed [61:0]  w_xx;
    logic signed [32:0]  w_omc;
    logic [35:0]         w_ten;
    logic [TERM_W-1:0]   w_rterm;
    logic [SUM_W:0]      w_sum_add;
    logic [SUM_W-1:0]    n_sum;
    logic signed [49:0]  w_gscore;
    logic signed [33:0]  w_n;
    logic [33:0]         w_mag;
    logic signed [DIV_W:0] w_q;
    logic signed [DIV_W:0] w_sc;
    logic [SCR_W-1:0]    w_sat;

    obe_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_phase (cor_phase),
        .o_busy  (cor_busy),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    obe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    obe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    obe_cdiv u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_num   (cd_num),
        .o_busy  (cd_busy),
        .o_quot  (cd_quot)
    );

    assign o_pop = (r_state == ST_IDLE) && i_cmd_valid;

    // unit requests
    always_comb begin
        cor_start = 1'b0;
        cor_phase = r_prod[51:20];
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DEN_W'(1);
        sq_start  = 1'b0;
        sq_val    = SQ_W'(div_quot);
        cd_start  = 1'b0;
        cd_num    = CD_N_W'(r_xx[60:25]);   // x*x / (4000 * 2^20)
        unique case (r_state)
            ST_DISPATCH: begin
                if (r_cmd.term_en && r_cmd.mode == MODE_RAST) begin
                    cor_start = 1'b1;
                    cor_phase = {r_cmd.x[19:0], 12'd0};
                end
                if (r_cmd.term_en && r_cmd.mode == MODE_GRIEW) begin
                    div_start = 1'b1;
                    div_num   = DIV_W'(1) << 60;
                    div_den   = DEN_W'(r_cmd.k) + DEN_W'(1);
                end
            end
            ST_G_DIV: begin
                sq_start = !div_busy;
            end
            ST_G_COS: begin
                cor_start = 1'b1;
                cd_start  = 1'b1;
            end
            ST_S_START: begin
                sq_start = 1'b1;
                sq_val   = {r_r2[41:0], 20'd0};
                cd_start = 1'b1;
                cd_num   = r_r2[41:3];          // r2 / 1000
            end
            ST_S_PHASE: begin
                cor_start = 1'b1;
            end
            ST_S_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_W'({w_mag[29:0], 20'd0});
                div_den   = r_prod[63:20];
            end
            default: ;
        endcase
    end

    // datapath pieces
    assign w_xx      = $signed(i_cmd.x) * $signed(i_cmd.x);
    assign w_omc     = $signed({1'b0, ONE_Q30}) - 33'(cor_cos);
    assign w_ten     = 36'({w_omc[31:0], 3'b000}) + 36'({w_omc[31:0], 1'b0});
    assign w_rterm   = TERM_W'(r_xx[60:20]) + TERM_W'(w_ten[35:10]);
    assign w_sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_term);
    assign n_sum     = (w_sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : w_sum_add[SUM_W-1:0];
    assign w_gscore  = $signed({2'b00, r_sum}) + $signed(50'(ONE_Q20))
                       - 50'(r_cp >>> 10);
    assign w_n       = $signed({2'b00, r_sin2}) - 34'sd536870912;
    assign w_mag     = w_n[33] ? 34'(-w_n) : 34'(w_n);
    assign w_q       = r_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    assign w_sc      = w_q + (DIV_W + 1)'(536870912);
    assign w_sat     = (r_score > SCORE_TOP) ? SCORE_TOP : r_score;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sum          <= '0;
            r_cp           <= ONE_Q30;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_xx    <= w_xx[60:0];
                        r_state <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    if (!r_cmd.term_en) begin
                        r_state <= ST_FIN;
                    end else begin
                        unique case (r_cmd.mode)
                            MODE_RAST:  r_state <= ST_R_WCOS;
                            MODE_GRIEW: r_state <= ST_G_DIV;
                            MODE_SCHAF: begin
                                r_term  <= TERM_W'(r_xx[60:20]);
                                r_state <= (r_cmd.k < IDX_W'(2)) ? ST_ADD : ST_FIN;
                            end
                            MODE_NONE:  r_state <= ST_FIN;
                        endcase
                    end
                end
                // Rastrigin term
                ST_R_WCOS: begin
                    if (!cor_busy) begin
                        r_term  <= w_rterm;
                        r_state <= ST_ADD;
                    end
                end
                // Griewangk: 1/sqrt(k+1), angle, cosine product
                ST_G_DIV: begin
                    if (!div_busy) begin
                        r_state <= ST_G_SQRT;
                    end
                end
                ST_G_SQRT: begin
                    if (!sq_busy) begin
                        r_rsq   <= sq_root;
                        r_state <= ST_G_MUL1;
                    end
                end
                ST_G_MUL1: begin
                    r_prod  <= $signed(r_cmd.x) * $signed({1'b0, r_rsq});
                    r_state <= ST_G_MUL2;
                end
                ST_G_MUL2: begin
                    r_prod  <= $signed(r_prod[61:30]) * $signed(TURNS_RAD);
                    r_state <= ST_G_COS;
                end
                ST_G_COS: begin
                    r_state <= ST_G_WCOS;
                end
                ST_G_WCOS: begin
                    if (!cor_busy) begin
                        r_prod  <= r_cp * cor_cos;
                        r_state <= ST_G_CP;
                    end
                end
                ST_G_CP: begin
                    r_cp    <= $signed(r_prod[61:30]);
                    r_state <= ST_G_WDIV;
                end
                ST_G_WDIV: begin
                    if (!cd_busy) begin
                        r_term  <= TERM_W'(cd_quot);
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_sum   <= n_sum;
                    r_state <= ST_FIN;
                end
                // end of vector
                ST_FIN: begin
                    if (!r_cmd.last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        unique case (r_cmd.mode)
                            MODE_RAST: begin
                                r_score <= SCR_W'(r_sum);
                                r_state <= ST_OUT;
                            end
                            MODE_GRIEW: begin
                                r_score <= w_gscore[SCR_W-1:0];
                                r_state <= ST_OUT;
                            end
                            MODE_SCHAF: begin
                                r_r2    <= (r_sum > R2_CAP) ? R2_CAP : r_sum;
                                r_state <= ST_S_START;
                            end
                            MODE_NONE: begin
                                r_score <= '0;
                                r_state <= ST_OUT;
                            end
                        endcase
                    end
                end
                // Schaffer F6 score
                ST_S_START: begin
                    r_state <= ST_S_WSQRT;
                end
                ST_S_WSQRT: begin
                    if (!sq_busy) begin
                        r_prod  <= $signed(64'(sq_root) * 64'(TURNS_RAD));
                        r_state <= ST_S_PHASE;
                    end
                end
                ST_S_PHASE: begin
                    r_state <= ST_S_WCOS;
                end
                ST_S_WCOS: begin
                    if (!cor_busy) begin
                        r_prod  <= cor_sin * cor_sin;
                        r_state <= ST_S_SIN2;
                    end
                end
                ST_S_SIN2: begin
                    r_sin2 <= r_prod[61:30];
                    if (!cd_busy) begin
                        r_d     <= ONE_Q20 + cd_quot;
                        r_state <= ST_S_DSQ;
                    end
                end
                ST_S_DSQ: begin
                    r_prod  <= $signed(64'(r_d) * 64'(r_d));
                    r_state <= ST_S_DIV;
                end
                ST_S_DIV: begin
                    r_neg   <= w_n[33];
                    r_state <= ST_S_WDIV;
                end
                ST_S_WDIV: begin
                    if (!div_busy) begin
                        r_score <= SCR_W'(w_sc >>> 10);
                        r_state <= ST_OUT;
                    end
                end
                // deliver and clear
                ST_OUT: begin
                    o_result_valid        <= 1'b1;
                    o_result.score_value  <= w_sat[SCORE_W-1:0];
                    o_result.dim_overflow <= r_cmd.ovf;
                    r_sum                 <= '0;
                    r_cp                  <= ONE_Q30;
                    r_state               <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: src/optimization_benchmark_evaluator.sv
// ----------------------------------------------------------------------------
// optimization_benchmark_evaluator
// Scores a coordinate stream with Rastrigin, Griewangk or Schaffer F6.
// ----------------------------------------------------------------------------
// Coordinates (Q11.20) enter on start while busy is low; a two-entry queue
// separates intake from the sequencer, so busy rises only when two items are
// waiting. Each result (Q15.20 score and overflow flag) appears for exactly
// one cycle on o_result with o_result_valid, and the receiver cannot stall
// it. Per coordinate the sequencer makes one pass through the shared CORDIC
// for Rastrigin; for Griewangk it forms 1/sqrt(k+1) through the bit-serial
// divider and the square root, then runs the CORDIC, while the divide by
// 4000 runs alongside; Schaffer uses no shared unit per coordinate. The last
// coordinate of a Schaffer vector adds the score (square root, sine, and the
// final divide). The bit-serial divider is what makes Griewangk and the
// Schaffer score the slowest.
// ----------------------------------------------------------------------------
module optimization_benchmark_evaluator
    import obe_pkg::*;
#(
    parameter int MAX_DIM      = 64,
    parameter int CORDIC_ITERS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_result_valid,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_mode r_mode;
    logic  w_pop, w_cmd_valid;
    t_cmd  w_cmd;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RAST;
        end else if (psel && penable && pwrite && paddr == ADDR_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    obe_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_mode      (r_mode),
        .o_busy      (busy),
        .i_pop       (w_pop),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    obe_back #(.CORDIC_ITERS(CORDIC_ITERS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_pop          (w_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

FILE: src/obe_checker.sv
// ----------------------------------------------------------------------------
// obe_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "optimization_benchmark_evaluator_macros.svh"

module obe_checker
    import obe_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      busy,
    input logic      pready,
    input logic      o_result_valid,
    input t_out_item o_result
);

    `OBE_ASSERT_ALWAYS(a_pready_high, pready, "pready low")
    `OBE_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> (!o_result_valid && !busy), "active after reset")
    `OBE_ASSERT(a_score_cap, o_result_valid |-> (o_result.score_value <= 35'd31457280000), "score above cap")
    `OBE_ASSERT(a_strobe_single, o_result_valid |=> !o_result_valid, "result strobe repeated")

endmodule

bind optimization_benchmark_evaluator obe_checker u_obe_checker (.*);

FILE: sim/tb_optimization_benchmark_evaluator.sv
// ----------------------------------------------------------------------------
// tb_optimization_benchmark_evaluator
// Self-checking bench for the benchmark evaluator. Coordinate vectors are
// streamed in bursts under every objective mode. A fixed-point scoring model
// in the bench predicts each score and overflow flag, and the result stream
// is compared against it item by item.
// ----------------------------------------------------------------------------
module tb_optimization_benchmark_evaluator;
    import obe_pkg::*;

    localparam int  DIMS       = 64;
    localparam int  ROT_STEPS  = 24;
    localparam int  DRAIN_WAIT = 400;    // covers one Griewangk coordinate and more
    localparam int  STALL_MAX  = 6000;
    localparam longint Q30     = 64'sd1073741824;
    localparam longint Q20     = 64'sd1048576;
    localparam longint XMAX    = 64'sd629145600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        o_result_valid;
    t_out_item   o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    optimization_benchmark_evaluator DUT (.*);

    always #5 i_clk = ~i_clk;

    // bench copy of block state
    t_mode   m_mode;
    longint  m_sum;
    longint  m_prod;
    int      m_idx;
    bit      m_ovf;
    longint  inv_root [DIMS];
    longint  arctan [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0};

    t_in_item  coord_fifo [$];
    t_out_item score_expect [$];
    bit        hold_tx = 1'b1;
    int        fail_cnt = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        stall_cnt = 0;

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // rotation CORDIC on a phase in 2^-32 turns, results in Q30
    task automatic rotate(input bit [31:0] ph, output longint co, output longint si);
        bit [31:0] quad, d;
        longint    z, x, y, dx, dy;
        quad = ((ph + 32'h2000_0000) >> 30) & 32'd3;
        d = ph - (quad << 30);
        z = (longint'($signed(d)) * 64'sd1686629713) >>> 30;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - arctan[i];
            end else begin
                x = x + dx; y = y - dy; z = z + arctan[i];
            end
        end
        if (x > Q30) x = Q30;
        if (x < -Q30) x = -Q30;
        if (y > Q30) y = Q30;
        if (y < -Q30) y = -Q30;
        case (quad)
            0: begin co = x;  si = y;  end
            1: begin co = -y; si = x;  end
            2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
        endcase
    endtask

    function automatic bit [31:0] to_turns(longint a);
        longint v;
        v = (a * 64'sd683565276) >>> 20;
        return v[31:0];
    endfunction

    function automatic void add_term(longint t);
        m_sum = m_sum + t;
        if (m_sum > 64'sd281474976710655) m_sum = 64'sd281474976710655;
    endfunction

    function automatic void clear_state();
        m_sum = 0;
        m_prod = Q30;
        m_idx = 0;
        m_ovf = 1'b0;
    endfunction

    // fold one accepted coordinate into the model; queue a score on the last one
    task automatic score_coord(input t_in_item it);
        longint    x, xx, c, s, a, score, r2, rt, sin2, den, q;
        longint unsigned d;
        t_out_item res;
        x = longint'(it.coord_value);
        xx = x * x;
        score = 0;
        if (m_idx >= DIMS) begin
            m_ovf = 1'b1;
        end else begin
            case (m_mode)
                MODE_RAST: begin
                    rotate(32'(x << 12), c, s);
                    add_term((xx >> 20) + ((10 * (Q30 - c)) >> 10));
                end
                MODE_GRIEW: begin
                    a = (x * inv_root[m_idx]) >>> 30;
                    rotate(to_turns(a), c, s);
                    add_term(xx / 64'sd4194304000);
                    m_prod = (m_prod * c) >>> 30;
                end
                MODE_SCHAF: begin
                    if (m_idx < 2) add_term(xx >> 20);
                end
                default: ;
            endcase
            m_idx++;
        end
        if (!it.last_coord) return;
        case (m_mode)
            MODE_RAST: score = m_sum;
            MODE_GRIEW: score = m_sum - (m_prod >>> 10) + Q20;
            MODE_SCHAF: begin
                r2 = (m_sum > (64'sd1 << 41)) ? (64'sd1 << 41) : m_sum;
                rt = int_sqrt(r2 << 20);
                rotate(to_turns(rt), c, s);
                sin2 = (s * s) >>> 30;
                d = longint'(Q20) + r2 / 1000;
                den = longint'((d * d) >> 20);
                q = ((sin2 - (Q30 >>> 1)) * Q20) / den;
                score = ((Q30 >>> 1) + q) >>> 10;
            end
            default: score = 0;
        endcase
        if (score > 64'sd31457280000) score = 64'sd31457280000;
        res.score_value = score[SCORE_W-1:0];
        res.dim_overflow = m_ovf;
        score_expect.push_back(res);
        clear_state();
    endtask

    // sender: bursts with random gaps, predicts on every accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) score_coord(i_item);
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (!hold_tx && coord_fifo.size() > 0) begin
                    start <= 1'b1;
                    i_item <= coord_fifo.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (score_expect.size() == 0) begin
                $error("unexpected result score=%0d", o_result.score_value);
                fail_cnt++;
            end else begin
                want = score_expect.pop_front();
                if (o_result.score_value !== want.score_value) begin
                    $error("score_value expected %0d actual %0d",
                           want.score_value, o_result.score_value);
                    fail_cnt++;
                end
                if (o_result.dim_overflow !== want.dim_overflow) begin
                    $error("dim_overflow expected %0d actual %0d",
                           want.dim_overflow, o_result.dim_overflow);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on sending cycles without any accepted item or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || !i_rst_n || hold_tx) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_mode(input t_mode md);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_MODE; pwdata <= 32'(md);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        m_mode = md;
    endtask

    function automatic void push_coord(longint v, bit last);
        t_in_item it;
        it.coord_value = v[COORD_W-1:0];
        it.last_coord = last;
        coord_fifo.push_back(it);
    endfunction

    function automatic longint rand_coord();
        case ($urandom_range(0, 3))
            0: return longint'($urandom_range(0, 1258291200)) - XMAX;
            1: return longint'($urandom_range(0, 20971520)) - 64'sd10485760;
            2: return (longint'($urandom_range(0, 20)) - 10) * Q20;
            default: return longint'($urandom_range(0, 2097152)) - Q20;
        endcase
    endfunction

    function automatic void push_vector(int len);
        for (int i = 0; i < len; i++) push_coord(rand_coord(), i == len - 1);
    endfunction

    // run the queued items, then let the block settle before any write
    task automatic run_phase();
        hold_tx = 1'b0;
        do @(posedge i_clk);
        while (coord_fifo.size() > 0 || start || score_expect.size() > 0);
        hold_tx = 1'b1;
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        for (int k = 0; k < DIMS; k++)
            inv_root[k] = int_sqrt((64'd1 << 60) / longint'(k + 1));
        m_mode = MODE_RAST;
        clear_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: +-XMAX, zero, +-1 and small values under each mode
        for (int md = 0; md < 4; md++) begin
            write_mode(t_mode'(md));
            push_coord(XMAX, 1'b0);
            push_coord(-XMAX, 1'b1);
            push_coord(0, 1'b1);
            push_coord(1, 1'b0);
            push_coord(-1, 1'b1);
            push_coord(3 * Q20, 1'b0);
            push_coord(-Q20 / 2, 1'b1);
            run_phase();
        end
        // too many coordinates, under Rastrigin and Griewangk
        write_mode(MODE_GRIEW);
        push_vector(66);
        run_phase();
        write_mode(MODE_RAST);
        push_vector(67);
        // partial vector left open, then finished under a different mode
        push_coord(Q20, 1'b0);
        push_coord(-2 * Q20, 1'b0);
        run_phase();
        write_mode(MODE_SCHAF);
        push_coord(5 * Q20, 1'b1);    // last coordinate of the open vector, scored as Schaffer
        push_coord(XMAX, 1'b0);
        push_coord(XMAX, 1'b0);
        push_coord(7, 1'b1);
        run_phase();

        // random phases, mostly short vectors with the odd long one
        sent = 0;
        while (sent < 320) begin
            write_mode(t_mode'($urandom_range(0, 3)));
            for (int v = 0; v < 8; v++) begin
                int len;
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(1, 8);
                push_vector(len);
                sent += len;
            end
            if ($urandom_range(0, 2) == 0) begin
                push_coord(rand_coord(), 1'b0);
                sent++;
            end
            run_phase();
        end

        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
